### design/bntf_pkg.sv
// Shared types, codes and the microcode ROM of the bounded number text formatter.
// No dependencies; used by bntf_bcd and bounded_number_text_formatter.
`default_nettype none

package bntf_pkg;

    localparam int unsigned DEF_POS_BITS   = 16;
    localparam int unsigned DEF_VALUE_BITS = 32;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned OUT_POS_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned MODE_W    = 3;

    // input modes
    localparam logic [MODE_W-1:0] MODE_CHAR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SDEC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UDEC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BIN    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REWIND = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_END = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED    = 2'd1;

    localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // microprogram addresses
    typedef logic [3:0] t_upc;
    localparam t_upc UPC_WAIT     = 4'd0;
    localparam t_upc UPC_CHAR     = 4'd1;
    localparam t_upc UPC_SIGN     = 4'd2;
    localparam t_upc UPC_DABBLE   = 4'd3;
    localparam t_upc UPC_SKIP_DEC = 4'd4;
    localparam t_upc UPC_EMIT_DEC = 4'd5;
    localparam t_upc UPC_SKIP_BIN = 4'd6;
    localparam t_upc UPC_EMIT_BIN = 4'd7;
    localparam t_upc UPC_REWIND   = 4'd8;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_CHAR,
        OP_SIGN,
        OP_DABBLE,
        OP_SKIP_DEC,
        OP_EMIT_DEC,
        OP_SKIP_BIN,
        OP_EMIT_BIN,
        OP_REWIND
    } t_op;

    // one control word: datapath operation, exit address, clear count on exit
    typedef struct packed {
        t_op  op;
        t_upc next;
        logic clr_cnt;
    } t_uop;

    // digit register commands
    typedef struct packed {
        logic clr;
        logic dabble;
        logic shift;
        logic in_bit;
    } t_bcd_ctl;

    function automatic t_uop uop_rom(input t_upc pc);
        t_uop u;
        unique case (pc)
            UPC_WAIT:     u = '{op: OP_WAIT,     next: UPC_WAIT,     clr_cnt: 1'b0};
            UPC_CHAR:     u = '{op: OP_CHAR,     next: UPC_WAIT,     clr_cnt: 1'b0};
            UPC_SIGN:     u = '{op: OP_SIGN,     next: UPC_DABBLE,   clr_cnt: 1'b0};
            UPC_DABBLE:   u = '{op: OP_DABBLE,   next: UPC_SKIP_DEC, clr_cnt: 1'b1};
            UPC_SKIP_DEC: u = '{op: OP_SKIP_DEC, next: UPC_EMIT_DEC, clr_cnt: 1'b0};
            UPC_EMIT_DEC: u = '{op: OP_EMIT_DEC, next: UPC_WAIT,     clr_cnt: 1'b0};
            UPC_SKIP_BIN: u = '{op: OP_SKIP_BIN, next: UPC_EMIT_BIN, clr_cnt: 1'b0};
            UPC_EMIT_BIN: u = '{op: OP_EMIT_BIN, next: UPC_WAIT,     clr_cnt: 1'b0};
            UPC_REWIND:   u = '{op: OP_REWIND,   next: UPC_WAIT,     clr_cnt: 1'b0};
            default:      u = '{op: OP_WAIT,     next: UPC_WAIT,     clr_cnt: 1'b0};
        endcase
        return u;
    endfunction

    // entry point of each mode; undefined modes stay in wait
    function automatic t_upc mode_entry(input logic [MODE_W-1:0] mode);
        t_upc a;
        unique case (mode)
            MODE_CHAR:   a = UPC_CHAR;
            MODE_SDEC:   a = UPC_SIGN;
            MODE_UDEC:   a = UPC_DABBLE;
            MODE_BIN:    a = UPC_SKIP_BIN;
            MODE_REWIND: a = UPC_REWIND;
            default:     a = UPC_WAIT;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### design/bntf_bcd.sv
// Decimal digit register: shift-and-add-3 conversion one bit a cycle, then
// digit-wide left shifts that present the top digit. Uses bntf_pkg.
`default_nettype none

module bntf_bcd #(
    parameter int unsigned NDIG = 10
) (
    input  wire logic              i_clk,
    input  wire bntf_pkg::t_bcd_ctl i_ctl,
    output logic [3:0]             o_top_digit
);

    localparam int unsigned BCD_W = NDIG * 4;

    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_bcd;
    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_comb begin
        if (i_ctl.clr) begin
            n_bcd = '0;
        end else if (i_ctl.dabble) begin
            n_bcd = {adj[BCD_W-2:0], i_ctl.in_bit};
        end else if (i_ctl.shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end else begin
            n_bcd = r_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

`default_nettype wire

### design/bounded_number_text_formatter.sv
// Bounded number text formatter: one operand in, its ASCII text out one
// character a word, each with its write position. Each item starts from the
// wait step. Char and rewind emit one word once the output register is free.
// Binary runs a leading-zero scan at one bit a cycle, then emission at one
// bit a cycle while the output register is free. Unsigned decimal runs the
// shift-and-add-3 loop once per operand bit, then a digit scan and emission
// step once per decimal digit; signed decimal adds a sign step first. Control
// is a microprogram of nine steps; input is taken only in its wait step.
// Undefined modes are taken and dropped. An append fails when blocked is set
// or position plus one exceeds buffer_end; a failure word has ok low and ends
// the run.
// Depends on bntf_pkg and bntf_bcd.
`default_nettype none

module bounded_number_text_formatter #(
    parameter int unsigned POS_BITS   = bntf_pkg::DEF_POS_BITS,
    parameter int unsigned VALUE_BITS = bntf_pkg::DEF_VALUE_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input words
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // value
    input  wire logic [bntf_pkg::MODE_W-1:0]           s_axis_tuser,  // mode
    // result words
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [bntf_pkg::CHAR_W+bntf_pkg::OUT_POS_W-1:0] m_axis_tdata, // char_code, write_pos
    output logic [0:0]                                 m_axis_tuser,  // ok
    output logic                                       m_axis_tlast,  // last
    // configuration writes
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [bntf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [bntf_pkg::CFG_DAT_W-1:0]        i_cfg_data
);

    localparam int unsigned NDIG  = (VALUE_BITS * 302 + 999) / 1000;
    localparam int unsigned CNT_W = $clog2(VALUE_BITS);
    localparam int unsigned CMP_W = ((POS_BITS > bntf_pkg::CFG_DAT_W) ?
                                     POS_BITS : bntf_pkg::CFG_DAT_W) + 1;
    localparam logic [CNT_W-1:0] CNT_LAST_BIT = CNT_W'(VALUE_BITS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST_DIG = CNT_W'(NDIG - 1);

    bntf_pkg::t_upc r_upc, n_upc;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [bntf_pkg::CFG_DAT_W-1:0] r_buf_end;
    logic                  r_blocked;

    logic                               r_out_valid, n_out_valid;
    logic [bntf_pkg::CHAR_W-1:0]        r_out_char, n_out_char;
    logic [bntf_pkg::OUT_POS_W-1:0]     r_out_pos, n_out_pos;
    logic                               r_out_ok, n_out_ok;
    logic                               r_out_last, n_out_last;

    bntf_pkg::t_uop     uop;
    bntf_pkg::t_bcd_ctl bcd_ctl;
    logic [3:0]         top_digit;
    logic               slot_free;
    logic               append_fail;
    logic [CMP_W-1:0]   pos_inc;
    logic               want;
    logic [bntf_pkg::CHAR_W-1:0] emit_char;
    logic               emit_last;
    logic               advance;

    bntf_bcd #(
        .NDIG (NDIG)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_ctl       (bcd_ctl),
        .o_top_digit (top_digit)
    );

    assign uop         = bntf_pkg::uop_rom(r_upc);
    assign slot_free   = !r_out_valid || m_axis_tready;
    assign pos_inc     = CMP_W'(r_pos) + CMP_W'(1);
    assign append_fail = r_blocked || (pos_inc > CMP_W'(r_buf_end));

    always_comb begin
        n_upc       = r_upc;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_pos   = r_out_pos;
        n_out_ok    = r_out_ok;
        n_out_last  = r_out_last;
        bcd_ctl     = '0;
        want        = 1'b0;
        emit_char   = bntf_pkg::ASCII_NUL;
        emit_last   = 1'b0;
        advance     = 1'b0;

        unique case (uop.op)
            bntf_pkg::OP_WAIT: begin
                if (s_axis_tvalid) begin
                    n_val       = s_axis_tdata[VALUE_BITS-1:0];
                    n_cnt       = '0;
                    bcd_ctl.clr = 1'b1;
                    n_upc       = bntf_pkg::mode_entry(s_axis_tuser);
                end
            end
            bntf_pkg::OP_CHAR: begin
                want      = 1'b1;
                emit_char = r_val[bntf_pkg::CHAR_W-1:0];
                emit_last = 1'b1;
            end
            bntf_pkg::OP_SIGN: begin
                if (r_val[VALUE_BITS-1]) begin
                    want      = 1'b1;
                    emit_char = bntf_pkg::ASCII_MINUS;
                end else begin
                    advance = 1'b1;
                end
            end
            bntf_pkg::OP_DABBLE: begin
                bcd_ctl.dabble = 1'b1;
                bcd_ctl.in_bit = r_val[VALUE_BITS-1];
                n_val          = r_val << 1;
                if (r_cnt == CNT_LAST_BIT) begin
                    advance = 1'b1;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            bntf_pkg::OP_SKIP_DEC: begin
                if (top_digit == 4'd0 && r_cnt != CNT_LAST_DIG) begin
                    bcd_ctl.shift = 1'b1;
                    n_cnt         = r_cnt + CNT_W'(1);
                end else begin
                    advance = 1'b1;
                end
            end
            bntf_pkg::OP_EMIT_DEC: begin
                want      = 1'b1;
                emit_char = bntf_pkg::ASCII_ZERO | {4'd0, top_digit};
                emit_last = (r_cnt == CNT_LAST_DIG);
            end
            bntf_pkg::OP_SKIP_BIN: begin
                if (!r_val[VALUE_BITS-1] && r_cnt != CNT_LAST_BIT) begin
                    n_val = r_val << 1;
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    advance = 1'b1;
                end
            end
            bntf_pkg::OP_EMIT_BIN: begin
                want      = 1'b1;
                emit_char = bntf_pkg::ASCII_ZERO | {7'd0, r_val[VALUE_BITS-1]};
                emit_last = (r_cnt == CNT_LAST_BIT);
            end
            bntf_pkg::OP_REWIND: begin
                // not subject to blocked or buffer_end
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = bntf_pkg::ASCII_NUL;
                    n_out_pos   = '0;
                    n_out_ok    = 1'b1;
                    n_out_last  = 1'b1;
                    n_pos       = '0;
                    advance     = 1'b1;
                end
            end
            default: begin
                n_upc = bntf_pkg::UPC_WAIT;
            end
        endcase

        // append one character; hold the step while the output register is full
        if (want && slot_free) begin
            n_out_valid = 1'b1;
            n_out_pos   = bntf_pkg::OUT_POS_W'(r_pos);
            if (append_fail) begin
                n_out_char = bntf_pkg::ASCII_NUL;
                n_out_ok   = 1'b0;
                n_out_last = 1'b1;
                n_upc      = bntf_pkg::UPC_WAIT;
            end else begin
                n_out_char = emit_char;
                n_out_ok   = 1'b1;
                n_out_last = emit_last;
                n_pos      = r_pos + POS_BITS'(1);
                if (uop.op == bntf_pkg::OP_SIGN) begin
                    n_val   = -r_val;
                    advance = 1'b1;
                end else if (uop.op == bntf_pkg::OP_CHAR) begin
                    advance = 1'b1;
                end else begin
                    if (uop.op == bntf_pkg::OP_EMIT_DEC) begin
                        bcd_ctl.shift = 1'b1;
                    end else begin
                        n_val = r_val << 1;
                    end
                    n_cnt = r_cnt + CNT_W'(1);
                    if (emit_last) begin
                        advance = 1'b1;
                    end
                end
            end
        end

        if (advance) begin
            n_upc = uop.next;
            if (uop.clr_cnt) begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= bntf_pkg::UPC_WAIT;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_buf_end   <= '0;
            r_blocked   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bntf_pkg::CFG_BUFFER_END: r_buf_end <= i_cfg_data;
                    bntf_pkg::CFG_BLOCKED:    r_blocked <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_out_char <= n_out_char;
        r_out_pos  <= n_out_pos;
        r_out_ok   <= n_out_ok;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = (uop.op == bntf_pkg::OP_WAIT);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pos, r_out_char};
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tlast  = r_out_last;

    // a failed append always ends the run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> r_out_last)
        else $error("failure word without last");

    // position only steps by one or returns to zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_pos != $past(r_pos)) |->
            (r_pos == $past(r_pos) + POS_BITS'(1) || r_pos == '0))
        else $error("write position jumped");

    // an undefined mode is dropped without leaving the wait step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != bntf_pkg::MODE_CHAR
         && s_axis_tuser != bntf_pkg::MODE_SDEC && s_axis_tuser != bntf_pkg::MODE_UDEC
         && s_axis_tuser != bntf_pkg::MODE_BIN && s_axis_tuser != bntf_pkg::MODE_REWIND)
        |=> (r_upc == bntf_pkg::UPC_WAIT))
        else $error("undefined mode started a run");

endmodule

`default_nettype wire

### verif/bntf_text_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bounded number text formatter: watches the input, result
// and configuration channels, predicts every text word and compares in order.
// Depends on bntf_pkg for mode codes, register indexes and character codes.
module bntf_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_end_check,
    output int          o_errors,
    output int          o_pending,
    output int          o_words,
    output int          o_refusals
);
    import bntf_pkg::*;

    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] pos;
        logic        ok;
        logic        last;
    } t_text_word;

    t_text_word  text_q[$];
    logic [15:0] pos_reg;
    logic [15:0] end_offset;
    logic        blocked_flag;
    int          mismatch_count;
    int          word_count;
    int          refusal_count;
    int          pending_count;
    bit          end_done;

    assign o_errors   = mismatch_count;
    assign o_pending  = pending_count;
    assign o_words    = word_count;
    assign o_refusals = refusal_count;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Build the text of one operand, then append it until the first refusal.
    task automatic format_operand(input logic [2:0] mode, input logic [31:0] value);
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [31:0] mag;
        int          msb;
        int          b;
        bit          failed;
        failed = 1'b0;
        case (mode)
            MODE_CHAR: text.push_back(value[7:0]);
            MODE_SDEC, MODE_UDEC: begin
                mag = value;
                if (mode == MODE_SDEC && value[31]) begin
                    text.push_back(ASCII_MINUS);
                    mag = -value;
                end
                do begin
                    digits.push_front(ASCII_ZERO + 8'(mag % 10));
                    mag = mag / 10;
                end while (mag != 0);
                text = {text, digits};
            end
            MODE_BIN: begin
                msb = 31;
                while (msb > 0 && !value[msb])
                    msb--;
                for (b = msb; b >= 0; b--)
                    text.push_back(value[b] ? ASCII_ZERO + 8'd1 : ASCII_ZERO);
            end
            MODE_REWIND: begin
                pos_reg = '0;
                text_q.push_back('{code: ASCII_NUL, pos: 16'd0, ok: 1'b1, last: 1'b1});
                return;
            end
            default: return;
        endcase
        foreach (text[i]) begin
            if (!failed) begin
                if (blocked_flag || ({1'b0, pos_reg} + 17'd1 > {1'b0, end_offset})) begin
                    text_q.push_back('{code: ASCII_NUL, pos: pos_reg, ok: 1'b0, last: 1'b1});
                    failed = 1'b1;
                end else begin
                    text_q.push_back('{code: text[i], pos: pos_reg, ok: 1'b1, last: 1'b0});
                    pos_reg = pos_reg + 16'd1;
                end
            end
        end
        if (!failed && text.size() > 0)
            text_q[text_q.size()-1].last = 1'b1;
    endtask

    task automatic check_word();
        t_text_word w;
        word_count++;
        if (!m_axis_tuser[0])
            refusal_count++;
        if (text_q.size() == 0) begin
            report_mismatch("result word with nothing expected", '0, 32'(m_axis_tdata));
            return;
        end
        w = text_q.pop_front();
        if (m_axis_tdata[7:0] != w.code)
            report_mismatch("char_code", 32'(w.code), 32'(m_axis_tdata[7:0]));
        if (m_axis_tdata[23:8] != w.pos)
            report_mismatch("write_pos", 32'(w.pos), 32'(m_axis_tdata[23:8]));
        if (m_axis_tuser[0] != w.ok)
            report_mismatch("ok", 32'(w.ok), 32'(m_axis_tuser[0]));
        if (m_axis_tlast != w.last)
            report_mismatch("last", 32'(w.last), 32'(m_axis_tlast));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_q.delete();
            pos_reg       = '0;
            end_offset    = '0;
            blocked_flag  = 1'b0;
            pending_count = 0;
            end_done      = 1'b0;
        end else begin
            // results out first: a word leaving now never belongs to a word entering now
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready)
                format_operand(s_axis_tuser, s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BUFFER_END: end_offset   = i_cfg_data;
                    CFG_BLOCKED:    blocked_flag = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (text_q.size() != 0)
                    report_mismatch("expected words never delivered", '0,
                                    32'(text_q.size()));
            end
            pending_count = text_q.size();
        end
    end

endmodule

### verif/bounded_number_text_formatter_tb.sv
`timescale 1ns / 1ps
// Top of the bounded number text formatter testbench: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on bntf_pkg, the block and
// bntf_text_checker.
module bounded_number_text_formatter_tb;
    import bntf_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam int NUM_PHASES    = 8;
    localparam int IDLE_PERCENT  = 37;

    localparam logic [15:0] PHASE_END [NUM_PHASES] =
        '{16'hFFFF, 16'd40, 16'd0, 16'd12, 16'hFFFF, 16'd1, 16'd300, 16'hFFFF};
    localparam bit PHASE_BLOCKED [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0};
    localparam int PHASE_ITEMS [NUM_PHASES]   = '{70, 70, 40, 60, 20, 40, 70, 130};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // value
    logic [2:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // char_code, write_pos
    logic [0:0]  m_axis_tuser;        // ok
    logic        m_axis_tlast;        // last
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        end_check = 1'b0;
    bit          steady = 1'b0;

    int error_count;
    int pending_words;
    int words_seen;
    int refusals_seen;
    int sent_by_mode [8];

    bounded_number_text_formatter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    bntf_text_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_end_check   (end_check),
        .o_errors      (error_count),
        .o_pending     (pending_words),
        .o_words       (words_seen),
        .o_refusals    (refusals_seen)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // random back-pressure on the result side
    always @(negedge i_clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    task automatic send_word(input logic [2:0] mode, input logic [31:0] value);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= value;
        sent_by_mode[mode]++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid, drain every expected word, then give a silent item time to finish
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_words != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return 32'($urandom_range(0, 20));
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h7FFF_FFFF >> $urandom_range(0, 31);
            5:       return -32'($urandom_range(1, 1000));
            default: return $urandom();
        endcase
    endfunction

    // returns 1 when the word is one the block acts on
    task automatic send_random_item(output bit counted);
        int          r;
        logic [2:0]  mode;
        r = $urandom_range(0, 99);
        if (r < 5)       mode = MODE_REWIND + 3'($urandom_range(1, 3));
        else if (r < 15) mode = MODE_REWIND;
        else if (r < 30) mode = MODE_CHAR;
        else if (r < 50) mode = MODE_SDEC;
        else if (r < 70) mode = MODE_UDEC;
        else             mode = MODE_BIN;
        send_word(mode, pick_value());
        counted = (mode <= MODE_REWIND);
    endtask

    initial begin
        int done;
        bit counted;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: empty destination, so the first append is refused
        send_word(MODE_CHAR, 32'h0000_0041);
        settle();
        write_reg(CFG_BUFFER_END, 16'hFFFF);
        write_reg(CFG_BLOCKED, 16'h0000);
        send_word(MODE_CHAR, 32'h0000_0000);
        send_word(MODE_CHAR, 32'hFFFF_FFFF);
        send_word(MODE_SDEC, 32'h0000_0000);
        send_word(MODE_SDEC, 32'h7FFF_FFFF);
        send_word(MODE_SDEC, 32'h8000_0000);
        send_word(MODE_SDEC, 32'hFFFF_FFFF);
        send_word(MODE_UDEC, 32'h0000_0000);
        send_word(MODE_UDEC, 32'hFFFF_FFFF);
        send_word(MODE_BIN, 32'h0000_0000);
        send_word(MODE_BIN, 32'h0000_0001);
        send_word(MODE_BIN, 32'hFFFF_FFFF);
        send_word(MODE_BIN, 32'h8000_0000);
        send_word(MODE_REWIND + 3'd1, 32'h5555_5555);
        send_word(MODE_REWIND + 3'd2, 32'hAAAA_AAAA);
        send_word(MODE_REWIND + 3'd3, 32'h1234_5678);
        send_word(MODE_REWIND, 32'h0000_0000);
        settle();
        // short destination: the run stops partway through a number
        write_reg(CFG_BUFFER_END, 16'd5);
        send_word(MODE_UDEC, 32'd1234567);
        send_word(MODE_REWIND, 32'h0000_0000);
        send_word(MODE_SDEC, 32'hFFFF_FFF6);
        settle();
        write_reg(CFG_BLOCKED, 16'h0001);
        send_word(MODE_CHAR, 32'h0000_0030);
        send_word(MODE_REWIND, 32'h0000_0000);
        send_word(MODE_BIN, 32'h0000_00FF);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_BUFFER_END, (p == 6) ? 16'($urandom_range(1, 65535)) : PHASE_END[p]);
            write_reg(CFG_BLOCKED, {15'($urandom()), PHASE_BLOCKED[p]});
            steady = (p == 3);
            done = 0;
            while (done < PHASE_ITEMS[p]) begin
                send_random_item(counted);
                if (counted)
                    done++;
            end
            settle();
        end
        steady = 1'b0;

        @(negedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("items sent: %0d char, %0d signed, %0d unsigned, %0d binary, %0d rewind",
                 sent_by_mode[MODE_CHAR], sent_by_mode[MODE_SDEC], sent_by_mode[MODE_UDEC],
                 sent_by_mode[MODE_BIN], sent_by_mode[MODE_REWIND]);
        $display("%0d text words checked, %0d refused appends, %0d mismatches",
                 words_seen, refusals_seen, error_count);
        if (error_count == 0)
            $display("bounded_number_text_formatter_tb: done, clean");
        else
            $display("bounded_number_text_formatter_tb: done, errors");
        $finish;
    end

    // watchdog: no word moving on any channel for too long ends the run
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("bounded_number_text_formatter_tb: done, errors");
        $finish;
    end

endmodule
